FILE: design/otid_pkg.sv
// shared types, field widths and codes for the order table
package otid_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int MODE_W  = 3;
  localparam int ID_W    = 32;
  localparam int SIDE_W  = 8;
  localparam int QTY_W   = 32;
  localparam int PRICE_W = 32;

  localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CANCEL  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REDUCE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DUMP    = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic [SIDE_W-1:0]         side;
    logic signed [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0]        price;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_MATCH,
    OP_APPLY,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [MODE_W-1:0] mode;
    entry_t            req;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_DUMP
  } state_t;

endpackage

FILE: design/otid_ifs.sv
// request and result channel interfaces of the order table
interface otid_in_if import otid_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [ID_W-1:0]           order_id;
  logic [SIDE_W-1:0]         order_side;
  logic signed [QTY_W-1:0]   amount;
  logic [PRICE_W-1:0]        price_fixed;

  modport source (output valid, mode, order_id, order_side, amount, price_fixed,
                  input ready);
  modport sink   (input valid, mode, order_id, order_side, amount, price_fixed,
                  output ready);
endinterface

interface otid_out_if import otid_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      entry_valid;
  logic [ID_W-1:0]           out_id;
  logic [SIDE_W-1:0]         out_side;
  logic signed [QTY_W-1:0]   out_quantity;
  logic [PRICE_W-1:0]        out_price;
  logic                      last;

  modport source (output valid, entry_valid, out_id, out_side, out_quantity, out_price,
                  last, input ready);
  modport sink   (input valid, entry_valid, out_id, out_side, out_quantity, out_price,
                  last, output ready);
endinterface

FILE: design/otid_cell.sv
// one table slot: holds an order, matches ids and hands entries to its neighbor
module otid_cell import otid_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd_i,
  input  logic      prev_valid_i,
  input  logic      prev_found_i,
  input  entry_t    next_ent_i,
  input  logic      next_valid_i,
  input  entry_t    head_ent_i,
  output entry_t    ent_o,
  output logic      valid_o,
  output logic      found_o
);

  entry_t ent_r, ent_nxt;
  logic   valid_r, valid_nxt;
  logic   hit_r, hit_nxt;

  always_comb begin
    ent_nxt   = ent_r;
    valid_nxt = valid_r;
    hit_nxt   = hit_r;
    unique case (cmd_i.op)
      OP_ADD: begin
        // first free slot takes the new order
        if (!valid_r && prev_valid_i) begin
          ent_nxt   = cmd_i.req;
          valid_nxt = 1'b1;
        end
      end
      OP_MATCH: begin
        hit_nxt = valid_r && (ent_r.id == cmd_i.req.id);
      end
      OP_APPLY: begin
        hit_nxt = 1'b0;
        priority if (cmd_i.mode == MODE_CANCEL) begin
          // matching slot and everything after it close the gap
          if (hit_r || prev_found_i) begin
            ent_nxt   = next_ent_i;
            valid_nxt = next_valid_i;
          end
        end else if (cmd_i.mode == MODE_REDUCE) begin
          if (hit_r && !prev_found_i) begin
            ent_nxt.qty = ent_r.qty - cmd_i.req.qty;
          end
        end else if (cmd_i.mode == MODE_REPLACE) begin
          if (hit_r && !prev_found_i) begin
            ent_nxt.qty   = cmd_i.req.qty;
            ent_nxt.price = cmd_i.req.price;
          end
        end else begin
          ent_nxt = ent_r;
        end
      end
      OP_ROTATE: begin
        // occupied slots rotate left, the head entry wraps to the last occupied one
        if (valid_r) begin
          ent_nxt = next_valid_i ? next_ent_i : head_ent_i;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_o   = ent_r;
  assign valid_o = valid_r;
  assign found_o = prev_found_i | hit_r;

endmodule

FILE: design/order_table_by_id.sv
// Order table: keeps up to DEPTH orders in insertion order in a row of slot cells.
// An add or an unused mode is done in its accept cycle. Cancel, reduce and replace
// also pass through the apply state: every cell compares its id in the accept cycle
// and the first match is resolved along the row and applied in the next; a cancel
// shifts the later entries down by one in that same cycle. A dump emits one beat
// per entry, or a single beat with no entry for an empty table, as the result side
// takes them; the row rotates one slot per emitted beat and is back in place when
// the dump ends. No new request is taken while an operation or a dump is under way;
// the last result beat may still be waiting in the output register when the next
// request is accepted.
module order_table_by_id import otid_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  otid_in_if.sink    in_bus,
  otid_out_if.source out_bus
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  entry_t             req_r;
  logic [MODE_W-1:0]  mode_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  entry_t             out_ent_r, out_ent_nxt;
  logic               out_entry_valid_r, out_entry_valid_nxt;
  logic               out_last_r, out_last_nxt;

  cell_cmd_t          cmd;
  entry_t             in_ent;
  logic               in_acc;

  entry_t             cell_ent   [DEPTH];
  logic               cell_valid [DEPTH];
  logic               cell_found [DEPTH];

  assign in_acc = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == ST_IDLE);

  assign in_ent.id    = in_bus.order_id;
  assign in_ent.side  = in_bus.order_side;
  assign in_ent.qty   = in_bus.amount;
  assign in_ent.price = in_bus.price_fixed;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic   prev_valid, prev_found, next_valid;
    entry_t next_ent;
    if (g == 0) begin : g_first
      assign prev_valid = 1'b1;
      assign prev_found = 1'b0;
    end else begin : g_mid
      assign prev_valid = cell_valid[g-1];
      assign prev_found = cell_found[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_ent   = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[g+1];
      assign next_ent   = cell_ent[g+1];
    end
    otid_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd_i        (cmd),
      .prev_valid_i (prev_valid),
      .prev_found_i (prev_found),
      .next_ent_i   (next_ent),
      .next_valid_i (next_valid),
      .head_ent_i   (cell_ent[0]),
      .ent_o        (cell_ent[g]),
      .valid_o      (cell_valid[g]),
      .found_o      (cell_found[g])
    );
  end

  assign out_load = !out_valid_r || out_bus.ready;

  always_comb begin
    state_nxt           = state_r;
    count_nxt           = count_r;
    idx_nxt             = idx_r;
    cmd.op              = OP_NONE;
    cmd.mode            = in_bus.mode;
    cmd.req             = in_ent;
    out_valid_nxt       = out_valid_r && !out_bus.ready;
    out_ent_nxt         = out_ent_r;
    out_entry_valid_nxt = out_entry_valid_r;
    out_last_nxt        = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_bus.mode == MODE_ADD) begin
            cmd.op = OP_ADD;
            if (count_r != CNT_W'(DEPTH)) begin
              count_nxt = count_r + 1'b1;
            end
          end else if (in_bus.mode == MODE_CANCEL || in_bus.mode == MODE_REDUCE ||
                       in_bus.mode == MODE_REPLACE) begin
            cmd.op    = OP_MATCH;
            state_nxt = ST_APPLY;
          end else if (in_bus.mode == MODE_DUMP) begin
            idx_nxt   = '0;
            state_nxt = ST_DUMP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_APPLY: begin
        cmd.op    = OP_APPLY;
        cmd.mode  = mode_r;
        cmd.req   = req_r;
        state_nxt = ST_IDLE;
        if (mode_r == MODE_CANCEL && cell_found[DEPTH-1]) begin
          count_nxt = count_r - 1'b1;
        end
      end
      ST_DUMP: begin
        cmd.req = req_r;
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (count_r == '0) begin
            out_ent_nxt         = '0;
            out_entry_valid_nxt = 1'b0;
            out_last_nxt        = 1'b1;
            state_nxt           = ST_IDLE;
          end else begin
            // head slot goes out, row rotates behind it
            cmd.op              = OP_ROTATE;
            out_ent_nxt         = cell_ent[0];
            out_entry_valid_nxt = 1'b1;
            out_last_nxt        = (idx_r == count_r - 1'b1);
            idx_nxt             = idx_r + 1'b1;
            if (idx_r == count_r - 1'b1) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_ent;
      mode_r <= in_bus.mode;
    end
    out_ent_r         <= out_ent_nxt;
    out_entry_valid_r <= out_entry_valid_nxt;
    out_last_r        <= out_last_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.entry_valid  = out_entry_valid_r;
  assign out_bus.out_id       = out_ent_r.id;
  assign out_bus.out_side     = out_ent_r.side;
  assign out_bus.out_quantity = out_ent_r.qty;
  assign out_bus.out_price    = out_ent_r.price;
  assign out_bus.last         = out_last_r;

endmodule
